// ===== hw/rtl/agx_pkg.sv =====
// Shared widths, register codes and constants of the asymmetric Gaussian tail evaluator.
package agx_pkg;

    // input sample and beat widths
    localparam int SAMPLE_WIDTH = 16;
    localparam int S_TDATA_W    = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int MAG_W        = ((SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16) + 1;
    localparam int DIFF_W       = MAG_W + 1;
    localparam int NUM_W        = ((MAG_W + 7) > 32) ? (MAG_W + 7) : 32;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SKEW       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_KNEE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_KNEE = 3'd4;

    // datapath widths
    localparam int WID_W   = 15;
    localparam int SCALE_W = 16;
    localparam int SIG_W   = WID_W + SCALE_W;
    localparam int RHO_W   = 16;
    localparam int RR_W    = 2 * RHO_W - 1;
    localparam int U_W     = 20;
    localparam int E_W     = 2 * U_W;
    localparam int Y_W     = 30;
    localparam int R_W     = 31;
    localparam int Q_FRAC  = 30;
    localparam int DENS_W  = 17;
    localparam int DENS_SHIFT = 14;
    localparam int M_TDATA_W  = 24;

    localparam logic [U_W-1:0] U_MAX   = {U_W{1'b1}};
    localparam logic [E_W-1:0] E_LIMIT = E_W'(64'd12 << 24);
    localparam logic signed [17:0] SCALE_ONE = 18'sd32768;
    localparam logic [R_W-1:0] R_ONE   = R_W'(64'd1 << Q_FRAC);
    localparam logic [2*R_W-1:0] R_HALF = (2*R_W)'(64'd1 << (Q_FRAC - 1));
    localparam logic [R_W:0] DENS_RND  = (R_W+1)'(64'd1 << (DENS_SHIFT - 1));

    // divider: two quotient bits per stage
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = U_W / DIV_STEPS;

    // series for exp: terms k = 12 down to 1, divide by k as multiply by ceil(2^34/k)
    localparam int HORNER_N    = 12;
    localparam int RECIP_W     = 35;
    localparam int RECIP_SHIFT = 34;
    localparam logic [RECIP_W-1:0] RECIP [HORNER_N] = '{
        35'd1431655766, 35'd1561806290, 35'd1717986919, 35'd1908874354,
        35'd2147483648, 35'd2454267027, 35'd2863311531, 35'd3435973837,
        35'd4294967296, 35'd5726623062, 35'd8589934592, 35'd17179869184
    };
    localparam int SQUARES = 4;

    // knee data that rides along with the divider
    typedef struct packed {
        logic [RHO_W-1:0] rho;
        logic [RR_W-1:0]  rr;
    } side_t;

    // per-item flags in the exp pipeline
    typedef struct packed {
        logic uf;
        logic tail;
    } flag_t;

endpackage

// ===== hw/rtl/agx_div.sv =====
// Pipelined restoring divider producing the saturated Q8.12 distance u.
module agx_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [agx_pkg::MAG_W-1:0]   in_mag,
    input  logic [agx_pkg::SIG_W-1:0]   in_sig,
    input  agx_pkg::side_t              in_side,
    output logic                        out_valid,
    output logic [agx_pkg::U_W-1:0]     out_u,
    output agx_pkg::side_t              out_side
);
    import agx_pkg::*;

    logic [DIV_STAGES:0] valid_reg;
    logic                sat_reg  [DIV_STAGES+1];
    logic [SIG_W-1:0]    rem_reg  [DIV_STAGES+1];
    logic [SIG_W-1:0]    sig_reg  [DIV_STAGES+1];
    logic [U_W-1:0]      q_reg    [DIV_STAGES+1];
    side_t               side_reg [DIV_STAGES+1];

    logic [NUM_W-1:0] num0;
    logic             sat0;

    // quotient overflows 20 bits when mag*2^7 >= sigma
    assign num0 = NUM_W'(in_mag) << 7;
    assign sat0 = num0 >= NUM_W'(in_sig);

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[DIV_STAGES-1:0], in_valid};
        end
    end

    // entry stage
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= sat0 ? '0 : num0[SIG_W-1:0];
            sig_reg[0]  <= in_sig;
            q_reg[0]    <= '0;
            sat_reg[0]  <= sat0;
            side_reg[0] <= in_side;
        end
    end

    // two restoring steps per stage
    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic [SIG_W-1:0] rem_c;
        logic [U_W-1:0]   q_c;
        logic [SIG_W:0]   t;

        always_comb begin
            rem_c = rem_reg[s];
            q_c   = q_reg[s];
            t     = '0;
            for (int j = 0; j < DIV_STEPS; j++) begin
                t = {rem_c, 1'b0};
                if (t >= {1'b0, sig_reg[s]}) begin
                    rem_c = SIG_W'(t - {1'b0, sig_reg[s]});
                    q_c   = {q_c[U_W-2:0], 1'b1};
                end else begin
                    rem_c = t[SIG_W-1:0];
                    q_c   = {q_c[U_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s+1]  <= rem_c;
                sig_reg[s+1]  <= sig_reg[s];
                q_reg[s+1]    <= q_c;
                sat_reg[s+1]  <= sat_reg[s];
                side_reg[s+1] <= side_reg[s];
            end
        end
    end

    assign out_valid = valid_reg[DIV_STAGES];
    assign out_u     = sat_reg[DIV_STAGES] ? U_MAX : q_reg[DIV_STAGES];
    assign out_side  = side_reg[DIV_STAGES];

`ifndef NO_ASSERTIONS
    // partial remainder always stays below the divisor
    a_rem_below_sig: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[DIV_STAGES] |-> rem_reg[DIV_STAGES] < sig_reg[DIV_STAGES])
        else $error("divider remainder not below divisor");
`endif

endmodule

// ===== hw/rtl/agx_exp.sv =====
// Pipelined exp(-E): twelve-term Horner series on E/16, four squarings, rounding.
module agx_exp (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [agx_pkg::Y_W-1:0]      in_y,
    input  logic                         in_uf,
    input  logic                         in_tail,
    output logic                         out_valid,
    output logic [agx_pkg::DENS_W-1:0]   out_density,
    output logic                         out_tail
);
    import agx_pkg::*;

    localparam int HS = 3 * HORNER_N;
    localparam int NV = HS + SQUARES + 2;

    logic [NV-1:0]    valid_reg;
    flag_t            flag_reg [NV];
    logic [Y_W-1:0]   y_reg    [HS+1];
    logic [Y_W-1:0]   hp_reg   [HORNER_N];
    logic [Y_W-1:0]   hq_reg   [HORNER_N];
    logic [R_W-1:0]   hr_reg   [HORNER_N];
    logic [R_W-1:0]   sq_reg   [SQUARES];
    logic [DENS_W-1:0] density_reg;

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[NV-2:0], in_valid};
        end
    end

    // flags and y travel alongside
    always_ff @(posedge aclk) begin
        if (en) begin
            flag_reg[0] <= '{uf: in_uf, tail: in_tail};
            y_reg[0]    <= in_y;
            for (int i = 1; i < NV; i++) flag_reg[i] <= flag_reg[i-1];
            for (int i = 1; i <= HS; i++) y_reg[i] <= y_reg[i-1];
        end
    end

    // Horner: r = 1 - floor(floor(y*r)/k), three stages per term
    for (genvar i = 0; i < HORNER_N; i++) begin : g_term
        logic [R_W-1:0]           r_src;
        logic [Y_W+R_W-1:0]       prod_a;
        logic [Y_W+RECIP_W-1:0]   prod_b;

        if (i == 0) begin : g_first
            assign r_src = R_ONE;
        end else begin : g_next
            assign r_src = hr_reg[i-1];
        end

        assign prod_a = (Y_W+R_W)'(y_reg[3*i]) * (Y_W+R_W)'(r_src);
        assign prod_b = (Y_W+RECIP_W)'(hp_reg[i]) * (Y_W+RECIP_W)'(RECIP[i]);

        always_ff @(posedge aclk) begin
            if (en) begin
                hp_reg[i] <= prod_a[Y_W+Q_FRAC-1:Q_FRAC];
                hq_reg[i] <= prod_b[Y_W+RECIP_SHIFT-1:RECIP_SHIFT];
                hr_reg[i] <= R_ONE - R_W'(hq_reg[i]);
            end
        end
    end

    // four rounded squarings
    for (genvar j = 0; j < SQUARES; j++) begin : g_sq
        logic [R_W-1:0]   s_src;
        logic [2*R_W-1:0] s_prod;

        if (j == 0) begin : g_first
            assign s_src = hr_reg[HORNER_N-1];
        end else begin : g_next
            assign s_src = sq_reg[j-1];
        end

        assign s_prod = (2*R_W)'(s_src) * (2*R_W)'(s_src) + R_HALF;

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_reg[j] <= s_prod[R_W+Q_FRAC-1:Q_FRAC];
            end
        end
    end

    // round Q30 to Q1.16, zero on underflow
    logic [R_W:0] rnd_sum;
    assign rnd_sum = (R_W+1)'(sq_reg[SQUARES-1]) + DENS_RND;

    always_ff @(posedge aclk) begin
        if (en) begin
            density_reg <= flag_reg[NV-2].uf ? '0
                                             : rnd_sum[DENS_SHIFT+DENS_W-1:DENS_SHIFT];
        end
    end

    assign out_valid   = valid_reg[NV-1];
    assign out_density = density_reg;
    assign out_tail    = flag_reg[NV-1].tail;

`ifndef NO_ASSERTIONS
    // series result stays within (0, 1.0]
    a_series_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[HS] |-> (hr_reg[HORNER_N-1] <= R_ONE) && (hr_reg[HORNER_N-1] != '0))
        else $error("series result out of range");
`endif

endmodule

// ===== hw/rtl/asym_gauss_exp_tail_eval_core.sv =====
// Top level of the asymmetric Gaussian with exponential tails evaluator.
// Takes one signed sample per beat and returns exp(-u^2/2) in the core or
// exp(rho*(rho/2-u)) beyond the knee, as Q1.16 (65536 = 1.0), with a tail flag.
// Fully pipelined: one sample per clock while the result side takes beats,
// through the 10-stage divider for u and the 36-stage exp series (12 terms,
// three stages each) plus four squaring stages. A stall on the result side
// holds the whole pipeline. Configuration writes are always taken (cfg_ready
// is high) and must only happen while no sample is in flight.
module asym_gauss_exp_tail_eval_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [agx_pkg::S_TDATA_W-1:0]     s_tdata,   // [15:0] sample
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [agx_pkg::M_TDATA_W-1:0]     m_tdata,   // [16:0] density, rest zero
    output logic                              m_tuser,   // [0] in_tail
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [agx_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [agx_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import agx_pkg::*;

    logic en;

    // pipeline advances unless a result is held
    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // configuration registers
    logic [15:0]      center_reg;
    logic [WID_W-1:0] width_reg;
    logic [15:0]      skew_reg;
    logic [RHO_W-1:0] lknee_reg;
    logic [RHO_W-1:0] rknee_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg <= 16'd0;
            width_reg  <= 15'd256;
            skew_reg   <= 16'd0;
            lknee_reg  <= 16'd8192;
            rknee_reg  <= 16'd8192;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_CENTER:     center_reg <= cfg_data;
                CFG_WIDTH:      width_reg  <= cfg_data[WID_W-1:0];
                CFG_SKEW:       skew_reg   <= cfg_data;
                CFG_LEFT_KNEE:  lknee_reg  <= cfg_data;
                CFG_RIGHT_KNEE: rknee_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage A: distance from mean, side selection
    logic signed [DIFF_W-1:0] d_a;
    logic signed [17:0]       sk_c;
    logic                     right_a;
    logic signed [17:0]       scale_c;
    logic [DIFF_W-1:0]        mag_c;

    assign d_a     = DIFF_W'(signed'(s_tdata[SAMPLE_WIDTH-1:0])) - DIFF_W'(signed'(center_reg));
    assign right_a = !d_a[DIFF_W-1] && (d_a != '0);
    assign sk_c    = (skew_reg == 16'h8000) ? -18'sd32767 : 18'(signed'(skew_reg));
    assign scale_c = right_a ? (SCALE_ONE + sk_c) : (SCALE_ONE - sk_c);
    assign mag_c   = right_a ? d_a : -d_a;

    logic                va_reg;
    logic [MAG_W-1:0]    mag_a_reg;
    logic [SCALE_W-1:0]  scale_a_reg;
    logic [WID_W-1:0]    w_a_reg;
    logic [RHO_W-1:0]    rho_a_reg;

    // stage B: sigma product and knee square
    logic                vb_reg;
    logic [MAG_W-1:0]    mag_b_reg;
    logic [SIG_W-1:0]    sig_b_reg;
    side_t               side_b_reg;
    logic [2*RHO_W-1:0]  rho_sq;

    assign rho_sq = (2*RHO_W)'(rho_a_reg) * (2*RHO_W)'(rho_a_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else if (en) begin
            va_reg <= s_tvalid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_a_reg   <= mag_c[MAG_W-1:0];
            scale_a_reg <= scale_c[SCALE_W-1:0];
            w_a_reg     <= (width_reg == '0) ? WID_W'(1) : width_reg;
            rho_a_reg   <= right_a ? rknee_reg : lknee_reg;

            mag_b_reg      <= mag_a_reg;
            sig_b_reg      <= SIG_W'(w_a_reg) * SIG_W'(scale_a_reg);
            side_b_reg.rho <= rho_a_reg;
            side_b_reg.rr  <= rho_sq[2*RHO_W-1:1];
        end
    end

    // u = (mag << 27) / sigma, saturated
    logic            div_valid;
    logic [U_W-1:0]  div_u;
    side_t           div_side;

    agx_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vb_reg),
        .in_mag    (mag_b_reg),
        .in_sig    (sig_b_reg),
        .in_side   (side_b_reg),
        .out_valid (div_valid),
        .out_u     (div_u),
        .out_side  (div_side)
    );

    // stages C..E: branch pick, exponent product, exponent and underflow
    logic             vc_reg, vd_reg, ve_reg;
    logic [U_W-1:0]   u_c_reg;
    side_t            side_c_reg;
    logic             tail_c_reg, tail_d_reg, tail_e_reg;
    logic [E_W-1:0]   prod_d_reg;
    logic [RR_W-1:0]  rr_d_reg;
    logic             uf_e_reg;
    logic [Y_W-1:0]   y_e_reg;
    logic [U_W-1:0]   mul_a;
    logic [E_W-1:0]   e_next;

    assign mul_a  = tail_c_reg ? U_W'(side_c_reg.rho) : u_c_reg;
    assign e_next = tail_d_reg ? (prod_d_reg - E_W'(rr_d_reg)) : (prod_d_reg >> 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end else if (en) begin
            vc_reg <= div_valid;
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            u_c_reg    <= div_u;
            side_c_reg <= div_side;
            tail_c_reg <= !(div_u < U_W'(div_side.rho));

            prod_d_reg <= E_W'(mul_a) * E_W'(u_c_reg);
            rr_d_reg   <= side_c_reg.rr;
            tail_d_reg <= tail_c_reg;

            uf_e_reg   <= e_next >= E_LIMIT;
            y_e_reg    <= {e_next[Y_W-3:0], 2'b00};
            tail_e_reg <= tail_d_reg;
        end
    end

    // exp(-E)
    logic               exp_valid;
    logic [DENS_W-1:0]  exp_density;
    logic               exp_tail;

    agx_exp u_exp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (ve_reg),
        .in_y        (y_e_reg),
        .in_uf       (uf_e_reg),
        .in_tail     (tail_e_reg),
        .out_valid   (exp_valid),
        .out_density (exp_density),
        .out_tail    (exp_tail)
    );

    assign m_tvalid = exp_valid;
    assign m_tdata  = M_TDATA_W'(exp_density);
    assign m_tuser  = exp_tail;

`ifndef NO_ASSERTIONS
    // density never exceeds 1.0
    a_density_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[DENS_W-1:0] <= DENS_W'(65536))
        else $error("density above 1.0");

    // tail exponent never goes negative
    a_tail_exp_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        vd_reg && tail_d_reg |-> prod_d_reg >= E_W'(rr_d_reg))
        else $error("negative tail exponent");

    // no beat right after reset
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result beat after reset");
`endif

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the asymmetric Gaussian tail evaluator core.
module testbench;
    import agx_pkg::*;

    localparam int LATENCY   = 58;
    localparam int MAX_CYCLE = 400000;

    // index that maps to no register
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    typedef struct {
        logic [16:0] density;
        logic        in_tail;
    } shape_t;

    // shadow copy of the registers
    logic signed [15:0] sh_center;
    logic [14:0]        sh_width;
    logic signed [15:0] sh_skew;
    logic [15:0]        sh_lknee;
    logic [15:0]        sh_rknee;

    shape_t shape_q[$];
    int     errors;
    longint cycle;
    int     hold_cycles;
    bit     stall_on;

    asym_gauss_exp_tail_eval_core uut (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // truncated series for exp(-e), e in Q24
    function automatic logic [16:0] exp_neg(input logic [63:0] e);
        logic [63:0] y;
        logic [63:0] r;
        if (e >= 64'd12 << 24)
            return 17'd0;
        y = e << 2;
        r = 64'd1 << 30;
        for (int k = 12; k >= 1; k--)
            r = (64'd1 << 30) - ((y * r) >> 30) / k;
        for (int k = 0; k < 4; k++)
            r = (r * r + (64'd1 << 29)) >> 30;
        return 17'((r + (64'd1 << 13)) >> 14);
    endfunction

    function automatic shape_t shape_of(input logic signed [15:0] smp);
        shape_t      res;
        longint      d;
        longint      sk;
        logic [63:0] mag, scale, rho, u, e, w;
        d  = longint'(smp) - longint'(sh_center);
        sk = (sh_skew < -32767) ? -32767 : longint'(sh_skew);
        w  = (sh_width == 0) ? 64'd1 : 64'(sh_width);
        if (d > 0) begin
            scale = 64'(32768 + sk);
            rho   = 64'(sh_rknee);
            mag   = 64'(d);
        end else begin
            scale = 64'(32768 - sk);
            rho   = 64'(sh_lknee);
            mag   = 64'(-d);
        end
        u = (mag << 27) / (w * scale);
        if (u > 64'hFFFFF) u = 64'hFFFFF;
        res.in_tail = !(u < rho);
        if (res.in_tail)
            e = rho * u - ((rho * rho) >> 1);
        else
            e = (u * u) >> 1;
        res.density = exp_neg(e);
        return res;
    endfunction

    // random gap, mostly short, now and then long
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // cycle counter and timeout
    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: random back-pressure plus a long forced hold
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else if (stall_on) begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        shape_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (shape_q.size() == 0) begin
                $error("unexpected result beat, density %0d", m_tdata[16:0]);
                errors++;
            end else begin
                want = shape_q.pop_front();
                if (m_tdata[16:0] !== want.density) begin
                    $error("density expected %0d actual %0d", want.density, m_tdata[16:0]);
                    errors++;
                end
                if (m_tdata[M_TDATA_W-1:17] !== '0) begin
                    $error("pad expected 0 actual %0h", m_tdata[M_TDATA_W-1:17]);
                    errors++;
                end
                if (m_tuser !== want.in_tail) begin
                    $error("in_tail expected %0d actual %0d", want.in_tail, m_tuser);
                    errors++;
                end
            end
        end
    end

    // valid stays high after the beat; drain() or a gap in the next call drops it
    task automatic send_sample(input logic signed [15:0] smp, input bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        shape_q.push_back(shape_of(smp));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (shape_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_CENTER:     sh_center = val;
            CFG_WIDTH:      sh_width  = val[14:0];
            CFG_SKEW:       sh_skew   = val;
            CFG_LEFT_KNEE:  sh_lknee  = val;
            CFG_RIGHT_KNEE: sh_rknee  = val;
            default: ;
        endcase
    endtask

    task automatic set_shape(input logic [15:0] c, input logic [15:0] w,
                             input logic [15:0] s, input logic [15:0] lk,
                             input logic [15:0] rk);
        write_reg(CFG_CENTER, c);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_SKEW, s);
        write_reg(CFG_LEFT_KNEE, lk);
        write_reg(CFG_RIGHT_KNEE, rk);
    endtask

    // corners at reset settings plus the special register values
    task automatic test_directed();
        logic signed [15:0] pts[$];
        pts = '{16'sd0, 16'sd1, -16'sd1, 16'sd32767, -16'sd32768, 16'sd256,
                -16'sd256, 16'sd512, -16'sd600, 16'sh5555, 16'shAAAA};
        foreach (pts[i]) send_sample(pts[i], 1'b0);
        drain();
        // zero width, skew at -1.0, zero knees, unknown index
        set_shape(16'd100, 16'd0, 16'h8000, 16'd0, 16'd0);
        write_reg(CFG_NO_REG, 16'hFFFF);
        send_sample(16'sd100, 1'b0);
        send_sample(16'sd101, 1'b0);
        send_sample(16'sd99, 1'b0);
        send_sample(-16'sd32768, 1'b0);
        drain();
        set_shape(16'h8000, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'd1);
        send_sample(16'sd32767, 1'b0);
        send_sample(-16'sd32768, 1'b0);
        send_sample(-16'sd32767, 1'b0);
        drain();
        set_shape(16'h7FFF, 16'd1, 16'h8001, 16'd1, 16'hFFFF);
        send_sample(16'sd32767, 1'b0);
        send_sample(16'sd32766, 1'b0);
        send_sample(-16'sd32768, 1'b0);
        drain();
    endtask

    // random samples, mostly around the mean, under random settings
    task automatic test_random(input int phases, input int per_phase);
        logic signed [15:0] smp;
        int span;
        for (int p = 0; p < phases; p++) begin
            set_shape(16'($urandom),
                      ($urandom_range(1, 3) == 1) ? 16'($urandom_range(1, 32767))
                                                  : 16'($urandom_range(16, 2048)),
                      16'($urandom),
                      ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(1, 20000)),
                      ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(1, 20000)));
            span = 8 * int'(sh_width) + 8;
            for (int i = 0; i < per_phase; i++) begin
                if ($urandom_range(0, 4) == 0)
                    smp = 16'($urandom);
                else
                    smp = 16'(int'(sh_center) + $urandom_range(0, 2 * span) - span);
                send_sample(smp, i % 40 >= 20);
            end
            drain();
        end
    endtask

    // long hold on the result side while samples keep coming
    task automatic test_backpressure();
        hold_cycles = 300;
        for (int i = 0; i < 120; i++)
            send_sample(16'($urandom), 1'b0);
        drain();
    endtask

    initial begin
        errors      = 0;
        cycle       = 0;
        hold_cycles = 0;
        stall_on    = 1'b0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        sh_center   = 16'sd0;
        sh_width    = 15'd256;
        sh_skew     = 16'sd0;
        sh_lknee    = 16'd8192;
        sh_rknee    = 16'd8192;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        stall_on = 1'b1;
        test_random(10, 100);
        test_backpressure();
        test_random(2, 35);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
